// ----- sv/esd_pkg.sv -----
// shared types, widths and reset constants for the edge swipe detector
`default_nettype none

package esd_pkg;

    // default sizes handed to the top level parameters
    localparam int COORD_BITS_DEF = 12;
    localparam int TICK_BITS_DEF  = 32;

    // configuration register widths
    localparam int EDGE_W     = 12;
    localparam int TRAVEL_W   = 12;
    localparam int DRIFT_W    = 12;
    localparam int SCREEN_W   = 13;
    localparam int COOLDOWN_W = 16;

    // configuration port sizes
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // result transaction width: fired flag and edge, padded to a byte
    localparam int OUT_BITS    = 3;
    localparam int OUT_TDATA_W = 8;

    // register reset values
    localparam logic [EDGE_W-1:0]     EDGE_WIDTH_RST = EDGE_W'(32);
    localparam logic [TRAVEL_W-1:0]   MIN_TRAVEL_RST = TRAVEL_W'(70);
    localparam logic [DRIFT_W-1:0]    MAX_DRIFT_RST  = DRIFT_W'(50);
    localparam logic [SCREEN_W-1:0]   SCREEN_RST     = SCREEN_W'(320);
    localparam logic [COOLDOWN_W-1:0] COOLDOWN_RST   = COOLDOWN_W'(800);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE_WIDTH     = 3'd0,
        CFG_MIN_TRAVEL     = 3'd1,
        CFG_MAX_DRIFT      = 3'd2,
        CFG_SCREEN_WIDTH   = 3'd3,
        CFG_COOLDOWN_TICKS = 3'd4
    } t_cfg_idx;

    // edge of the current press
    typedef enum logic [1:0] {
        EDGE_NONE  = 2'd0,
        EDGE_LEFT  = 2'd1,
        EDGE_RIGHT = 2'd2
    } t_edge;

    // configuration bundle seen by the core
    typedef struct packed {
        logic [EDGE_W-1:0]     edge_width;
        logic [TRAVEL_W-1:0]   min_travel;
        logic [DRIFT_W-1:0]    max_drift;
        logic [SCREEN_W-1:0]   screen_width;
        logic [COOLDOWN_W-1:0] cooldown_ticks;
    } t_cfg;

    // per-sample result from the core
    typedef struct packed {
        logic  fired;
        t_edge swipe_edge;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/esd_cfg_regs.sv -----
// configuration register file for the edge swipe detector
`default_nettype none

module esd_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [esd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [esd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output esd_pkg::t_cfg                       o_cfg
);
    import esd_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.edge_width     <= EDGE_WIDTH_RST;
            r_cfg.min_travel     <= MIN_TRAVEL_RST;
            r_cfg.max_drift      <= MAX_DRIFT_RST;
            r_cfg.screen_width   <= SCREEN_RST;
            r_cfg.cooldown_ticks <= COOLDOWN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_EDGE_WIDTH:     r_cfg.edge_width     <= i_cfg_wdata[EDGE_W-1:0];
                CFG_MIN_TRAVEL:     r_cfg.min_travel     <= i_cfg_wdata[TRAVEL_W-1:0];
                CFG_MAX_DRIFT:      r_cfg.max_drift      <= i_cfg_wdata[DRIFT_W-1:0];
                CFG_SCREEN_WIDTH:   r_cfg.screen_width   <= i_cfg_wdata[SCREEN_W-1:0];
                CFG_COOLDOWN_TICKS: r_cfg.cooldown_ticks <= i_cfg_wdata[COOLDOWN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- sv/esd_core.sv -----
// press tracking state and swipe decision for one sample
`default_nettype none

module esd_core #(
    parameter int COORD_BITS = esd_pkg::COORD_BITS_DEF,
    parameter int TICK_BITS  = esd_pkg::TICK_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  esd_pkg::t_cfg              i_cfg,
    input  wire logic                  i_adv,
    input  wire logic                  i_pressed,
    input  wire logic [COORD_BITS-1:0] i_x,
    input  wire logic [COORD_BITS-1:0] i_y,
    input  wire logic [TICK_BITS-1:0]  i_now,
    output esd_pkg::t_result           o_result
);
    import esd_pkg::*;

    // signed compare width covering coordinates and the screen width
    localparam int CMP_W = ((COORD_BITS > SCREEN_W) ? COORD_BITS : SCREEN_W) + 1;

    logic                  r_finger_down;
    logic                  r_already_fired;
    t_edge                 r_start_edge;
    logic [COORD_BITS-1:0] r_start_x;
    logic [COORD_BITS-1:0] r_start_y;
    logic [TICK_BITS-1:0]  r_cooldown_end;

    logic                  n_finger_down;
    logic                  n_already_fired;
    t_edge                 n_start_edge;
    logic [COORD_BITS-1:0] n_start_x;
    logic [COORD_BITS-1:0] n_start_y;
    logic [TICK_BITS-1:0]  n_cooldown_end;

    logic [TICK_BITS-1:0]  remain;
    logic                  cooling;
    logic                  first;
    logic signed [CMP_W-1:0] xs;
    logic signed [CMP_W-1:0] ews;
    logic signed [CMP_W-1:0] right_limit;
    t_edge                 class_edge;
    logic                  prev_fired;
    logic signed [CMP_W-1:0] dx;
    logic signed [CMP_W-1:0] dy;
    logic signed [CMP_W-1:0] dy_abs;
    logic signed [CMP_W-1:0] travel;
    logic signed [CMP_W-1:0] drift;
    logic                  travel_ok;
    logic                  fire;

    // cooldown window check with wraparound
    assign remain  = r_cooldown_end - i_now;
    assign cooling = (remain != '0) && !remain[TICK_BITS-1];

    // classify a fresh press against the two borders
    assign first       = !r_finger_down;
    assign xs          = $signed({{(CMP_W-COORD_BITS){1'b0}}, i_x});
    assign ews         = $signed({{(CMP_W-EDGE_W){1'b0}}, i_cfg.edge_width});
    assign right_limit = $signed({{(CMP_W-SCREEN_W){1'b0}}, i_cfg.screen_width}) - ews;

    always_comb begin
        if (xs <= ews) begin
            class_edge = EDGE_LEFT;
        end else if (xs >= right_limit) begin
            class_edge = EDGE_RIGHT;
        end else begin
            class_edge = EDGE_NONE;
        end
    end

    // start point for this sample: latched now or kept from the press
    assign n_start_x    = (i_pressed && first) ? i_x : r_start_x;
    assign n_start_y    = (i_pressed && first) ? i_y : r_start_y;
    assign prev_fired   = first ? 1'b0 : r_already_fired;

    // travel and drift relative to the start point
    assign dx     = $signed({{(CMP_W-COORD_BITS){1'b0}}, i_x}) -
                    $signed({{(CMP_W-COORD_BITS){1'b0}}, n_start_x});
    assign dy     = $signed({{(CMP_W-COORD_BITS){1'b0}}, i_y}) -
                    $signed({{(CMP_W-COORD_BITS){1'b0}}, n_start_y});
    assign dy_abs = dy[CMP_W-1] ? -dy : dy;
    assign travel = $signed({{(CMP_W-TRAVEL_W){1'b0}}, i_cfg.min_travel});
    assign drift  = $signed({{(CMP_W-DRIFT_W){1'b0}}, i_cfg.max_drift});

    always_comb begin
        n_start_edge = i_pressed ? (first ? class_edge : r_start_edge) : EDGE_NONE;
        travel_ok    = 1'b0;
        if (dy_abs <= drift) begin
            case (n_start_edge)
                EDGE_LEFT:  travel_ok = (dx >= travel);
                EDGE_RIGHT: travel_ok = (dx <= -travel);
                default:    travel_ok = 1'b0;
            endcase
        end
    end

    // firing decision and next press state
    assign fire            = i_pressed && !cooling && !prev_fired && travel_ok;
    assign n_finger_down   = i_pressed;
    assign n_already_fired = i_pressed && (prev_fired || fire);
    assign n_cooldown_end  = fire ? (i_now + TICK_BITS'(i_cfg.cooldown_ticks))
                                  : r_cooldown_end;

    // state moves only when a sample passes to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_finger_down   <= 1'b0;
            r_already_fired <= 1'b0;
            r_start_edge    <= EDGE_NONE;
            r_start_x       <= '0;
            r_start_y       <= '0;
            r_cooldown_end  <= '0;
        end else if (i_adv) begin
            r_finger_down   <= n_finger_down;
            r_already_fired <= n_already_fired;
            r_start_edge    <= n_start_edge;
            r_start_x       <= n_start_x;
            r_start_y       <= n_start_y;
            r_cooldown_end  <= n_cooldown_end;
        end
    end

    assign o_result.fired      = fire;
    assign o_result.swipe_edge = n_start_edge;

    // a fired press never fires twice
    a_fired_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && fire) |=> r_already_fired)
        else $error("already_fired not set after a firing");

    a_fired_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_already_fired |-> r_finger_down)
        else $error("already_fired set with no finger down");

    a_released_no_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_finger_down |-> (r_start_edge == EDGE_NONE))
        else $error("start edge kept after release");

    a_fire_sets_cooldown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && fire) |=> (r_cooldown_end ==
            $past(i_now + TICK_BITS'(i_cfg.cooldown_ticks))))
        else $error("cooldown end not loaded on firing");

endmodule

`default_nettype wire

// ----- sv/edge_swipe_detector.sv -----
// edge swipe detector top level: input register, core, result register
//
//  channel  | direction | tdata fields, lowest bit first
//  s_axis   | in        | touch_pressed, x_pos, y_pos, now_tick
//  m_axis   | out       | swipe_fired, swipe_edge
//  cfg      | in        | i_cfg_index selects register, i_cfg_wdata value
//
// one sample per cycle sustained while m_axis takes results; input register, then result register
// the decision is compares, differences and one add between the input and result registers
// synchronous active low reset restores register defaults and clears press state
// a stalled result holds its register; the input register still takes one more sample
// press state advances only as a sample moves into the result register
`default_nettype none

module edge_swipe_detector #(
    parameter int COORD_BITS = esd_pkg::COORD_BITS_DEF,
    parameter int TICK_BITS  = esd_pkg::TICK_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // touch_pressed, x_pos, y_pos, now_tick, zero pad
    input  wire logic [((1+2*COORD_BITS+TICK_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // swipe_fired, swipe_edge, zero pad
    output logic [esd_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic                              i_cfg_we,
    input  wire logic [esd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [esd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import esd_pkg::*;

    localparam int X_LO = 1;
    localparam int Y_LO = X_LO + COORD_BITS;
    localparam int T_LO = Y_LO + COORD_BITS;

    t_cfg    cfg;
    t_result result;

    logic                  r_in_valid;
    logic                  r_in_pressed;
    logic [COORD_BITS-1:0] r_in_x;
    logic [COORD_BITS-1:0] r_in_y;
    logic [TICK_BITS-1:0]  r_in_now;
    logic                  r_out_valid;
    t_result               r_out;
    logic                  adv;
    logic                  in_take;

    esd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    esd_core #(
        .COORD_BITS (COORD_BITS),
        .TICK_BITS  (TICK_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_adv     (adv),
        .i_pressed (r_in_pressed),
        .i_x       (r_in_x),
        .i_y       (r_in_y),
        .i_now     (r_in_now),
        .o_result  (result)
    );

    // handshake: sample moves on when the result slot is free or draining
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_pressed <= s_axis_tdata[0];
            r_in_x       <= s_axis_tdata[X_LO +: COORD_BITS];
            r_in_y       <= s_axis_tdata[Y_LO +: COORD_BITS];
            r_in_now     <= s_axis_tdata[T_LO +: TICK_BITS];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, r_out.swipe_edge, r_out.fired};

    // a fired result always names an edge
    a_fire_has_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fired) |-> (r_out.swipe_edge != EDGE_NONE))
        else $error("swipe fired without an edge");

    // a held sample blocks a new input transaction
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |-> !s_axis_tready)
        else $error("input accepted while input register is full");

    // a result taken with nothing behind it empties the slot
    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && m_axis_tready && !adv) |=> !r_out_valid)
        else $error("result register not released after transaction");

endmodule

`default_nettype wire

// ----- tb/edge_swipe_detector_tb.sv -----
// self-checking testbench for the edge swipe detector with random idling and config phases
module edge_swipe_detector_tb;
    import esd_pkg::*;

    localparam int COORD_W    = COORD_BITS_DEF;
    localparam int TICK_W     = TICK_BITS_DEF;
    localparam int IN_TDATA_W = ((1 + 2*COORD_W + TICK_W + 7) / 8) * 8;
    localparam int MAX_COORD  = (1 << COORD_W) - 1;
    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 94;
    // index with no register behind it, written once to check it is ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    // one polled touch sample
    typedef struct {
        logic              pressed;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [TICK_W-1:0]  tick;
    } t_touch;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    // touch_pressed, x_pos, y_pos, now_tick, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // swipe_fired, swipe_edge, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;

    edge_swipe_detector i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    t_touch  touch_queue[$];
    t_result swipe_results_due[$];
    int      fail_count    = 0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;
    logic [TICK_W-1:0] tick_now = '0;

    // predictor copy of the registers and press state
    t_cfg cfg_model = '{edge_width: EDGE_WIDTH_RST, min_travel: MIN_TRAVEL_RST,
                        max_drift: MAX_DRIFT_RST, screen_width: SCREEN_RST,
                        cooldown_ticks: COOLDOWN_RST};
    logic               finger_down   = 1'b0;
    logic               already_fired = 1'b0;
    t_edge              start_edge    = EDGE_NONE;
    logic [COORD_W-1:0] start_x       = '0;
    logic [COORD_W-1:0] start_y       = '0;
    logic [TICK_W-1:0]  cooldown_end  = '0;

    // advance the press state by one sample and return the expected result
    function automatic t_result detect_swipe(t_touch s);
        t_result           res;
        logic [TICK_W-1:0] remain;
        logic              cooling;
        logic              travel_ok;
        int                right_limit;
        int                dx;
        int                dy;
        remain  = cooldown_end - s.tick;
        cooling = (remain != '0) && !remain[TICK_W-1];
        res.fired = 1'b0;
        if (!s.pressed) begin
            finger_down   = 1'b0;
            already_fired = 1'b0;
            start_edge    = EDGE_NONE;
        end else begin
            if (!finger_down) begin
                finger_down   = 1'b1;
                already_fired = 1'b0;
                start_x       = s.x;
                start_y       = s.y;
                right_limit   = int'(cfg_model.screen_width) - int'(cfg_model.edge_width);
                if (int'(s.x) <= int'(cfg_model.edge_width))
                    start_edge = EDGE_LEFT;
                else if (int'(s.x) >= right_limit)
                    start_edge = EDGE_RIGHT;
                else
                    start_edge = EDGE_NONE;
            end
            dx = int'(s.x) - int'(start_x);
            dy = int'(s.y) - int'(start_y);
            if (dy < 0)
                dy = -dy;
            travel_ok = 1'b0;
            if (dy <= int'(cfg_model.max_drift)) begin
                if (start_edge == EDGE_LEFT)
                    travel_ok = dx >= int'(cfg_model.min_travel);
                else if (start_edge == EDGE_RIGHT)
                    travel_ok = dx <= -int'(cfg_model.min_travel);
            end
            if (!cooling && !already_fired && start_edge != EDGE_NONE && travel_ok) begin
                already_fired = 1'b1;
                cooldown_end  = s.tick + TICK_W'(cfg_model.cooldown_ticks);
                res.fired     = 1'b1;
            end
        end
        res.swipe_edge = start_edge;
        return res;
    endfunction

    // sender: present queued samples, predict on each transaction
    always @(posedge i_clk) begin
        t_touch s;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                s.pressed = s_axis_tdata[0];
                s.x       = s_axis_tdata[COORD_W:1];
                s.y       = s_axis_tdata[2*COORD_W:COORD_W+1];
                s.tick    = s_axis_tdata[2*COORD_W+TICK_W:2*COORD_W+1];
                swipe_results_due.push_back(detect_swipe(s));
            end
            if (touch_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s = touch_queue.pop_front();
                s_axis_tdata  <= IN_TDATA_W'({s.tick, s.y, s.x, s.pressed});
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, compare each result transaction
    always @(posedge i_clk) begin
        t_result exp_res;
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (swipe_results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got tdata %h",
                         $time, m_axis_tdata);
                fail_count++;
            end else begin
                exp_res = swipe_results_due.pop_front();
                if (m_axis_tdata[0] !== exp_res.fired) begin
                    $display("%0t: swipe_fired expected %0b got %0b",
                             $time, exp_res.fired, m_axis_tdata[0]);
                    fail_count++;
                end
                if (m_axis_tdata[2:1] !== exp_res.swipe_edge) begin
                    $display("%0t: swipe_edge expected %0d got %0d",
                             $time, exp_res.swipe_edge, m_axis_tdata[2:1]);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [COORD_W-1:0] clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > MAX_COORD)
            return COORD_W'(MAX_COORD);
        return COORD_W'(v);
    endfunction

    task automatic queue_touch(logic p, int x, int y, logic [TICK_W-1:0] t);
        t_touch s;
        s.pressed = p;
        s.x       = clamp_coord(x);
        s.y       = clamp_coord(y);
        s.tick    = t;
        touch_queue.push_back(s);
    endtask

    // a press near an edge moving inward, or anywhere moving either way, with some vertical drift
    task automatic queue_swipe(ref int count);
        int side;
        int x;
        int y;
        int y0;
        int dir;
        int steps;
        int stride;
        int drift;
        side = $urandom_range(4);
        if (side <= 1) begin
            x   = $urandom_range(0, cfg_model.edge_width);
            dir = 1;
        end else if (side <= 3) begin
            x   = int'(cfg_model.screen_width) - int'(cfg_model.edge_width)
                  + int'($urandom_range(0, 15));
            dir = -1;
        end else begin
            x   = $urandom_range(0, MAX_COORD);
            dir = $urandom_range(1) ? 1 : -1;
        end
        y0     = $urandom_range(0, MAX_COORD);
        steps  = $urandom_range(1, 8);
        stride = int'(cfg_model.min_travel) / int'($urandom_range(1, 4))
                 + int'($urandom_range(0, 10));
        drift  = int'(cfg_model.max_drift) + 3;
        queue_touch(1'b1, x, y0, tick_now);
        count++;
        repeat (steps) begin
            tick_now += TICK_W'($urandom_range(0, 120));
            x += dir * int'($urandom_range(0, stride));
            y  = y0 + int'($urandom_range(0, 2*drift)) - drift;
            queue_touch(1'b1, x, y, tick_now);
            count++;
        end
        // now and then the finger never lifts before the next press
        if ($urandom_range(9) != 0) begin
            tick_now += TICK_W'($urandom_range(1, 50));
            queue_touch(1'b0, $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                        tick_now);
            count++;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_EDGE_WIDTH:     cfg_model.edge_width     = val[EDGE_W-1:0];
            CFG_MIN_TRAVEL:     cfg_model.min_travel     = val[TRAVEL_W-1:0];
            CFG_MAX_DRIFT:      cfg_model.max_drift      = val[DRIFT_W-1:0];
            CFG_SCREEN_WIDTH:   cfg_model.screen_width   = val[SCREEN_W-1:0];
            CFG_COOLDOWN_TICKS: cfg_model.cooldown_ticks = val[COOLDOWN_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(int ew, int travel, int drift, int sw, int cool);
        write_reg(CFG_EDGE_WIDTH, CFG_DATA_W'(ew));
        write_reg(CFG_MIN_TRAVEL, CFG_DATA_W'(travel));
        write_reg(CFG_MAX_DRIFT, CFG_DATA_W'(drift));
        write_reg(CFG_SCREEN_WIDTH, CFG_DATA_W'(sw));
        write_reg(CFG_COOLDOWN_TICKS, CFG_DATA_W'(cool));
    endtask

    // wait until every sample has its result, then let the pipe settle
    task automatic wait_drained();
        while (touch_queue.size() != 0 || s_axis_tvalid || swipe_results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // stimulus: directed samples, then random phases under changing settings
    initial begin
        int count;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default settings: edge 32, travel 70, drift 50, screen 320, cooldown 800
        queue_touch(1'b0, MAX_COORD, MAX_COORD, 32'hFFFF_FFFF);
        queue_touch(1'b1, 0, 0, 32'h0000_0000);
        queue_touch(1'b1, 100, 40, 32'd10);
        queue_touch(1'b1, 200, 40, 32'd20);
        queue_touch(1'b0, 0, 0, 32'd30);
        // cooldown blocks until its end tick is reached exactly
        queue_touch(1'b1, 10, 100, 32'd100);
        queue_touch(1'b1, 150, 100, 32'd200);
        queue_touch(1'b1, 150, 100, 32'd810);
        queue_touch(1'b0, 0, 0, 32'd900);
        // right edge start, drift one over the limit, then on the limit
        queue_touch(1'b1, 300, 500, 32'd1700);
        queue_touch(1'b1, 230, 551, 32'd1701);
        queue_touch(1'b1, 230, 550, 32'd1702);
        queue_touch(1'b0, 0, 0, 32'd1800);
        // start in the middle never fires
        queue_touch(1'b1, 160, 0, 32'd2600);
        queue_touch(1'b1, 0, 0, 32'd2601);
        queue_touch(1'b0, 0, 0, 32'd2602);
        // cooldown end half the tick range behind counts as expired
        queue_touch(1'b1, MAX_COORD, MAX_COORD, 32'h8000_0000);
        queue_touch(1'b1, 4000, MAX_COORD, 32'h8000_0001);
        queue_touch(1'b0, 0, 0, 32'h8000_0002);
        // firing just before the tick wraps, cooldown running across the wrap
        queue_touch(1'b1, 5, 2000, 32'hFFFF_FF00);
        queue_touch(1'b1, MAX_COORD, 2000, 32'hFFFF_FF01);
        queue_touch(1'b0, 0, 0, 32'h0000_0010);
        queue_touch(1'b1, 0, MAX_COORD, 32'h0000_0100);
        queue_touch(1'b1, MAX_COORD, 4045, 32'h0000_0221);
        queue_touch(1'b0, 0, 0, 32'h0000_0300);
        wait_drained();
        tick_now = 32'h0000_1000;

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: ;
                1: begin
                    write_all(0, 0, 0, 0, 0);
                    write_reg(CFG_UNMAPPED, 16'hFFFF);
                end
                2: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: write_all(100, 40, 20, 4096, 300);
                4: write_all(2000, 100, 4095, 1000, 1000);
                5: write_all(1, 4095, 4095, 1, 65535);
                default: write_all($urandom_range(0, 300), $urandom_range(0, 400),
                                   $urandom_range(0, 200), $urandom_range(1, 4096),
                                   $urandom_range(0, 3000));
            endcase
            @(posedge i_clk);
            case (phase % 4)
                0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
                1: begin send_idle_pct <= 87; stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  stall_pct <= 87; end
                default: begin send_idle_pct <= 24; stall_pct <= 24; end
            endcase
            count = 0;
            while (count < PHASE_ITEMS) begin
                case ($urandom_range(19))
                    0: tick_now = $urandom();
                    1: tick_now = 32'hFFFF_FFFF - TICK_W'($urandom_range(0, 2000));
                    default: tick_now += TICK_W'($urandom_range(1, 300));
                endcase
                if ($urandom_range(99) < 75) begin
                    queue_swipe(count);
                end else begin
                    // noise: any field value, tick anywhere
                    queue_touch($urandom_range(1), $urandom_range(0, MAX_COORD),
                                $urandom_range(0, MAX_COORD), $urandom());
                    count++;
                end
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("edge_swipe_detector_tb: PASS");
        else
            $display("edge_swipe_detector_tb: FAIL");
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("edge_swipe_detector_tb: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/esd_pkg.sv
sv/esd_cfg_regs.sv
sv/esd_core.sv
sv/edge_swipe_detector.sv
tb/edge_swipe_detector_tb.sv
